>>> sv/mke_pkg.sv
// Shared types and the character pattern table of the Morse keying encoder.
// Used by mke_front, mke_fifo and mke_back; depends on nothing.
package mke_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned MAX_ELEMS = 5;
	localparam int unsigned ELEM_CW   = 3;
	localparam int unsigned GAP_CW    = 3;

	localparam logic [GAP_CW-1:0] SHORT_GAP_UNITS = 3'd4;
	localparam logic [GAP_CW-1:0] LONG_GAP_UNITS  = 3'd7;
	localparam logic [GAP_CW-1:0] TRAIL_UNITS     = 3'd2;

	// dash bit i = 1 means element i is a dash; element 0 is keyed first
	typedef struct packed {
		logic                  hit;
		logic [ELEM_CW-1:0]    n_elem;
		logic [MAX_ELEMS-1:0]  dash;
	} glyph_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic                  is_char;
		logic                  long_gap;
		logic [ELEM_CW-1:0]    n_elem;
		logic [MAX_ELEMS-1:0]  dash;
	} desc_t;

	function automatic glyph_t glyph_lookup(input logic [CHAR_W-1:0] code);
		glyph_t g;
		g.hit = 1'b1;
		unique case (code)
			8'h41: begin g.n_elem = 3'd2; g.dash = 5'b00010; end // A
			8'h42: begin g.n_elem = 3'd4; g.dash = 5'b00001; end // B
			8'h43: begin g.n_elem = 3'd4; g.dash = 5'b00101; end // C
			8'h44: begin g.n_elem = 3'd3; g.dash = 5'b00001; end // D
			8'h45: begin g.n_elem = 3'd1; g.dash = 5'b00000; end // E
			8'h46: begin g.n_elem = 3'd4; g.dash = 5'b00100; end // F
			8'h47: begin g.n_elem = 3'd3; g.dash = 5'b00011; end // G
			8'h48: begin g.n_elem = 3'd4; g.dash = 5'b00000; end // H
			8'h49: begin g.n_elem = 3'd2; g.dash = 5'b00000; end // I
			8'h4A: begin g.n_elem = 3'd4; g.dash = 5'b01110; end // J
			8'h4B: begin g.n_elem = 3'd3; g.dash = 5'b00101; end // K
			8'h4C: begin g.n_elem = 3'd4; g.dash = 5'b00010; end // L
			8'h4D: begin g.n_elem = 3'd2; g.dash = 5'b00011; end // M
			8'h4E: begin g.n_elem = 3'd2; g.dash = 5'b00001; end // N
			8'h4F: begin g.n_elem = 3'd3; g.dash = 5'b00111; end // O
			8'h50: begin g.n_elem = 3'd4; g.dash = 5'b00110; end // P
			8'h51: begin g.n_elem = 3'd4; g.dash = 5'b01011; end // Q
			8'h52: begin g.n_elem = 3'd3; g.dash = 5'b00010; end // R
			8'h53: begin g.n_elem = 3'd3; g.dash = 5'b00000; end // S
			8'h54: begin g.n_elem = 3'd1; g.dash = 5'b00001; end // T
			8'h55: begin g.n_elem = 3'd3; g.dash = 5'b00100; end // U
			8'h56: begin g.n_elem = 3'd4; g.dash = 5'b01000; end // V
			8'h57: begin g.n_elem = 3'd3; g.dash = 5'b00110; end // W
			8'h58: begin g.n_elem = 3'd4; g.dash = 5'b01001; end // X
			8'h59: begin g.n_elem = 3'd4; g.dash = 5'b01101; end // Y
			8'h5A: begin g.n_elem = 3'd4; g.dash = 5'b00011; end // Z
			8'h30: begin g.n_elem = 3'd5; g.dash = 5'b11111; end // 0
			8'h31: begin g.n_elem = 3'd5; g.dash = 5'b11110; end // 1
			8'h32: begin g.n_elem = 3'd5; g.dash = 5'b11100; end // 2
			8'h33: begin g.n_elem = 3'd5; g.dash = 5'b11000; end // 3
			8'h34: begin g.n_elem = 3'd5; g.dash = 5'b10000; end // 4
			8'h35: begin g.n_elem = 3'd5; g.dash = 5'b00000; end // 5
			8'h36: begin g.n_elem = 3'd5; g.dash = 5'b00001; end // 6
			8'h37: begin g.n_elem = 3'd5; g.dash = 5'b00011; end // 7
			8'h38: begin g.n_elem = 3'd5; g.dash = 5'b00111; end // 8
			8'h39: begin g.n_elem = 3'd5; g.dash = 5'b01111; end // 9
			default: begin
				g.hit    = 1'b0;
				g.n_elem = '0;
				g.dash   = '0;
			end
		endcase
		return g;
	endfunction

endpackage

>>> sv/morse_keying_encoder.sv
// Morse keying encoder: one ASCII character in, 4 to 22 keying units out.
// A character's first unit passes through the descriptor queue and the sequencer register before it appears.
// Throughput: one unit per cycle unless m_tready stalls the output; a character has 4..22 units
// (4 or 7 for a space), and the next starts without a gap if it is already queued.
// The front end keeps accepting while the descriptor queue has room.
// Reset: arst_n clears the queue, the sequencer and the previous-space flag.
module morse_keying_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] key_on, [7:1] zero
	output logic       m_tlast    // last_unit
);

	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_valid;
	mke_pkg::desc_t push_desc;
	mke_pkg::desc_t q_head;
	logic           key_on;

	mke_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_code    (s_tdata),
		.queue_full (q_full),
		.in_ready   (s_tready),
		.push       (push),
		.push_desc  (push_desc)
	);

	mke_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	mke_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_key   (key_on),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'd0, key_on};

endmodule

>>> sv/mke_front.sv
// Front end: classifies each character into a keying descriptor.
// Uses mke_pkg (glyph table, desc_t); feeds mke_fifo.
module mke_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [mke_pkg::CHAR_W-1:0]    in_code,
	input  logic                          queue_full,
	output logic                          in_ready,
	output logic                          push,
	output mke_pkg::desc_t                push_desc
);

	logic            prev_space_q;
	mke_pkg::glyph_t glyph;

	assign glyph    = mke_pkg::glyph_lookup(in_code);
	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_desc.is_char  = glyph.hit;
		push_desc.long_gap = !glyph.hit && prev_space_q;
		push_desc.n_elem   = glyph.n_elem;
		push_desc.dash     = glyph.dash;
	end

	// unmatched codes count as spaces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_space_q <= 1'b0;
		end else if (push) begin
			prev_space_q <= !glyph.hit;
		end
	end

endmodule

>>> sv/mke_fifo.sv
// Short descriptor queue between the front end and the unit sequencer.
// Uses mke_pkg::desc_t.
module mke_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mke_pkg::desc_t push_desc,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output mke_pkg::desc_t head
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	mke_pkg::desc_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/mke_back.sv
// Back end: walks a descriptor one keying unit per cycle, unless out_ready stalls, into an output register.
// Uses mke_pkg (desc_t, gap lengths); pops mke_fifo.
module mke_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mke_pkg::desc_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_key,
	output logic           out_last
);

	logic                               active_q;
	logic                               elems_q;
	logic [mke_pkg::MAX_ELEMS-1:0]      dash_q;
	logic [mke_pkg::ELEM_CW-1:0]        left_q;
	logic [1:0]                         unit_q;
	logic [mke_pkg::GAP_CW-1:0]         zcnt_q;
	logic                               out_valid_q;
	logic                               out_key_q;
	logic                               out_last_q;

	logic can_emit;
	logic unit_key;
	logic unit_last;
	logic elem_end;

	always_comb begin
		if (elems_q) begin
			unit_key = dash_q[0] ? (unit_q != 2'd3) : (unit_q == 2'd0);
			elem_end = dash_q[0] ? (unit_q == 2'd3) : (unit_q == 2'd1);
		end else begin
			unit_key = 1'b0;
			elem_end = 1'b0;
		end
	end

	assign unit_last = !elems_q && (zcnt_q == mke_pkg::GAP_CW'(1));
	assign can_emit  = active_q && (!out_valid_q || out_ready);
	assign q_pop     = q_valid && (!active_q || (can_emit && unit_last));

	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
			end else if (can_emit && unit_last) begin
				active_q <= 1'b0;
			end
			if (can_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sequencer payload and output data: no reset needed
	always_ff @(posedge clk) begin
		if (can_emit) begin
			out_key_q  <= unit_key;
			out_last_q <= unit_last;
		end
		if (q_pop) begin
			elems_q <= q_head.is_char;
			dash_q  <= q_head.dash;
			left_q  <= q_head.n_elem;
			unit_q  <= 2'd0;
			if (q_head.is_char) begin
				zcnt_q <= mke_pkg::TRAIL_UNITS;
			end else begin
				zcnt_q <= q_head.long_gap ? mke_pkg::LONG_GAP_UNITS
				                          : mke_pkg::SHORT_GAP_UNITS;
			end
		end else if (can_emit) begin
			if (elems_q) begin
				if (elem_end) begin
					// advance to the next element, or into the closing gap
					unit_q <= 2'd0;
					dash_q <= dash_q >> 1;
					left_q <= left_q - mke_pkg::ELEM_CW'(1);
					if (left_q == mke_pkg::ELEM_CW'(1)) begin
						elems_q <= 1'b0;
					end
				end else begin
					unit_q <= unit_q + 2'd1;
				end
			end else begin
				zcnt_q <= zcnt_q - mke_pkg::GAP_CW'(1);
			end
		end
	end

endmodule

>>> sv/mke_checker.sv
// Port-level checks for morse_keying_encoder, attached by bind.
// Depends only on the top level's port list.
module mke_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	logic xfer;
	logic prev_on_q;

	assign xfer = m_tvalid && m_tready;

	// key level of the most recent output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_on_q <= 1'b0;
		end else if (xfer) begin
			prev_on_q <= m_tdata[0];
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped before transfer");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	a_last_is_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[0])
		else $error("final unit of a character keyed on");

	a_gap_after_on: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && prev_on_q |-> !m_tlast)
		else $error("character ended right after a keyed-on unit");

endmodule

bind morse_keying_encoder mke_checker u_mke_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
